// ===== hdl/ttsmt_pkg.sv =====
// Shared types, constants and handshake structs for the transmit timestamp match table.
package ttsmt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int TAG_BITS_DEF    = 8;

  localparam int REF_W       = 12;
  localparam int REF_IN_W    = 16;
  localparam int SEC_W       = 32;
  localparam int NSEC_W      = 30;
  localparam int TS_W        = 62;
  localparam int TIME_W      = 32;
  localparam int AGE_W       = 16;
  localparam int STATUS_W    = 3;
  localparam int TAG_OUT_W   = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [NSEC_W-1:0] NS_PER_SEC    = 30'd1000000000;
  localparam logic [AGE_W-1:0]  AGE_LIMIT_RST = 16'd5000;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_AGE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    MODE_STORE  = 2'd0,
    MODE_REPORT = 2'd1,
    MODE_TICK   = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED   = 3'd0,
    ST_DISABLED = 3'd1,
    ST_FULL     = 3'd2,
    ST_DUP      = 3'd3,
    ST_MATCH    = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_AGED     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_RESULT,
    S_SEEK,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan_issue;
    logic idx_clear;
    logic seek_step;
    logic emit_read;
    logic emit;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t op;
    logic  enable;
    logic  scan_last;
    logic  aged_any;
    logic  seek_hit;
    logic  emit_more;
    logic  out_free;
  } dp_status_t;

endpackage

// ===== hdl/ttsmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ttsmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ttsmt_ctrl.sv =====
// Controller state machine: sequences table scans, result loads and aged-entry emission.
module ttsmt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            mode,
  input  ttsmt_pkg::dp_status_t sts,
  output logic                  in_stall,
  output ttsmt_pkg::ctrl_cmd_t  cmd
);

  ttsmt_pkg::state_t state;
  ttsmt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttsmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ttsmt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (mode)
            ttsmt_pkg::MODE_STORE,
            ttsmt_pkg::MODE_REPORT: begin
              state_next = sts.enable ? ttsmt_pkg::S_SCAN : ttsmt_pkg::S_RESULT;
            end
            ttsmt_pkg::MODE_TICK: begin
              state_next = ttsmt_pkg::S_SCAN;
            end
            default: begin
              state_next = ttsmt_pkg::S_IDLE;
            end
          endcase
        end
      end
      ttsmt_pkg::S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = ttsmt_pkg::S_TAIL;
        end
      end
      ttsmt_pkg::S_TAIL: begin
        cmd.idx_clear = 1'b1;
        if (sts.op == ttsmt_pkg::MODE_TICK) begin
          state_next = sts.aged_any ? ttsmt_pkg::S_SEEK : ttsmt_pkg::S_IDLE;
        end else begin
          state_next = ttsmt_pkg::S_RESULT;
        end
      end
      ttsmt_pkg::S_RESULT: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ttsmt_pkg::S_IDLE;
        end
      end
      ttsmt_pkg::S_SEEK: begin
        if (sts.seek_hit) begin
          cmd.emit_read = 1'b1;
          state_next    = ttsmt_pkg::S_WAIT;
        end else begin
          cmd.seek_step = 1'b1;
        end
      end
      ttsmt_pkg::S_WAIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.emit_more ? ttsmt_pkg::S_SEEK : ttsmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ttsmt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/ttsmt_dpath.sv =====
// Datapath: entry store, scan compare, timestamp arithmetic, config and result register.
module ttsmt_dpath #(
  parameter int TABLE_DEPTH = ttsmt_pkg::TABLE_DEPTH_DEF,
  parameter int TAG_BITS    = ttsmt_pkg::TAG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ttsmt_pkg::ctrl_cmd_t                cmd,
  output ttsmt_pkg::dp_status_t               sts,
  input  logic [1:0]                          mode,
  input  logic [TAG_BITS-1:0]                 packet_tag,
  input  logic [ttsmt_pkg::REF_IN_W-1:0]      report_ref,
  input  logic [ttsmt_pkg::SEC_W-1:0]         report_sec,
  input  logic [ttsmt_pkg::NSEC_W-1:0]        report_nsec,
  input  logic                                cfg_valid,
  input  logic [ttsmt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ttsmt_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ttsmt_pkg::STATUS_W-1:0]      status,
  output logic [ttsmt_pkg::REF_W-1:0]         ref_number,
  output logic [ttsmt_pkg::TAG_OUT_W-1:0]     tag_out,
  output logic [ttsmt_pkg::TS_W-1:0]          timestamp_ns,
  output logic                                last
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int RAM_W = ttsmt_pkg::REF_W + TAG_BITS + ttsmt_pkg::TIME_W;
  localparam logic [TABLE_DEPTH-1:0] ONE = TABLE_DEPTH'(1);

  logic                                enable;
  logic [ttsmt_pkg::AGE_W-1:0]         age_limit;
  logic [ttsmt_pkg::TIME_W-1:0]        now_ticks;
  logic [ttsmt_pkg::REF_W-1:0]         next_ref;

  ttsmt_pkg::mode_t                    op;
  logic [ttsmt_pkg::REF_W-1:0]         key;
  logic [TAG_BITS-1:0]                 tag_cap;
  logic [ttsmt_pkg::SEC_W-1:0]         sec_cap;
  logic [ttsmt_pkg::NSEC_W-1:0]        nsec_cap;
  logic [ttsmt_pkg::TS_W-1:0]          prod;
  logic [ttsmt_pkg::TS_W-1:0]          ts;

  logic [IDX_W-1:0]                    idx;
  logic [IDX_W-1:0]                    idx_d;
  logic                                rd_v;

  logic                                dup;
  logic                                hit_found;
  logic [IDX_W-1:0]                    hit_slot;
  logic [TAG_BITS-1:0]                 hit_tag;
  logic                                free_found;
  logic [IDX_W-1:0]                    free_slot;
  logic [TABLE_DEPTH-1:0]              aged_mask;
  logic [TABLE_DEPTH-1:0]              aged_mask_next;
  logic [TABLE_DEPTH-1:0]              valid;
  logic [TABLE_DEPTH-1:0]              valid_next;

  logic [RAM_W-1:0]                    ram_rdata;
  logic [RAM_W-1:0]                    ram_wdata;
  logic                                ram_we;
  logic                                ram_re;

  logic [ttsmt_pkg::REF_W-1:0]         rd_ref;
  logic [TAG_BITS-1:0]                 rd_tag;
  logic [ttsmt_pkg::TIME_W-1:0]        rd_time;
  logic [ttsmt_pkg::TIME_W-1:0]        elapsed;
  logic                                slot_valid;
  logic                                ref_eq;
  logic                                aged_now;
  logic                                store_ok;
  logic                                out_free;

  logic                                load;
  logic [ttsmt_pkg::STATUS_W-1:0]      status_next;
  logic [ttsmt_pkg::REF_W-1:0]         ref_next;
  logic [TAG_BITS-1:0]                 tag_sel;
  logic [TAG_BITS+ttsmt_pkg::TAG_OUT_W-1:0] tag_ext;
  logic [ttsmt_pkg::TS_W-1:0]          ts_next;
  logic                                last_next;

  ttsmt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign rd_ref  = ram_rdata[RAM_W-1 -: ttsmt_pkg::REF_W];
  assign rd_tag  = ram_rdata[ttsmt_pkg::TIME_W +: TAG_BITS];
  assign rd_time = ram_rdata[ttsmt_pkg::TIME_W-1:0];

  assign slot_valid = valid[idx_d];
  assign ref_eq     = slot_valid && (rd_ref == key);
  assign elapsed    = now_ticks - rd_time;
  assign aged_now   = rd_v && slot_valid && (op == ttsmt_pkg::MODE_TICK) &&
                      (elapsed > {{(ttsmt_pkg::TIME_W-ttsmt_pkg::AGE_W){1'b0}}, age_limit});
  assign aged_mask_next = aged_now ? (aged_mask | (ONE << idx_d)) : aged_mask;

  assign store_ok  = enable && !dup && free_found;
  assign ram_we    = cmd.finish && (op == ttsmt_pkg::MODE_STORE) && store_ok;
  assign ram_wdata = {key, tag_cap, now_ticks};
  assign ram_re    = cmd.scan_issue || cmd.emit_read;
  assign out_free  = !out_valid || !out_stall;

  assign sts.op        = op;
  assign sts.enable    = enable;
  assign sts.scan_last = (idx == IDX_W'(TABLE_DEPTH-1));
  assign sts.aged_any  = |aged_mask_next;
  assign sts.seek_hit  = aged_mask[idx];
  assign sts.emit_more = |(aged_mask & ~(ONE << idx));
  assign sts.out_free  = out_free;

  always_comb begin
    valid_next = valid;
    if (ram_we) begin
      valid_next[free_slot] = 1'b1;
    end
    if (cmd.finish && (op == ttsmt_pkg::MODE_REPORT) && enable && hit_found) begin
      valid_next[hit_slot] = 1'b0;
    end
    if (cmd.emit) begin
      valid_next[idx] = 1'b0;
    end
  end

  always_comb begin
    load        = cmd.finish || cmd.emit;
    status_next = ttsmt_pkg::ST_AGED;
    ref_next    = key;
    tag_sel     = '0;
    ts_next     = '0;
    last_next   = 1'b1;
    if (cmd.emit) begin
      status_next = ttsmt_pkg::ST_AGED;
      ref_next    = rd_ref;
      tag_sel     = rd_tag;
      last_next   = !sts.emit_more;
    end else begin
      case (op)
        ttsmt_pkg::MODE_STORE: begin
          tag_sel = tag_cap;
          if (!enable) begin
            status_next = ttsmt_pkg::ST_DISABLED;
          end else if (dup) begin
            status_next = ttsmt_pkg::ST_DUP;
          end else if (!free_found) begin
            status_next = ttsmt_pkg::ST_FULL;
          end else begin
            status_next = ttsmt_pkg::ST_STORED;
          end
        end
        ttsmt_pkg::MODE_REPORT: begin
          if (!enable) begin
            status_next = ttsmt_pkg::ST_DISABLED;
          end else if (hit_found) begin
            status_next = ttsmt_pkg::ST_MATCH;
            tag_sel     = hit_tag;
            ts_next     = ts;
          end else begin
            status_next = ttsmt_pkg::ST_UNKNOWN;
          end
        end
        default: begin
          status_next = ttsmt_pkg::ST_AGED;
        end
      endcase
    end
    tag_ext = {{ttsmt_pkg::TAG_OUT_W{1'b0}}, tag_sel};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b1;
      age_limit <= ttsmt_pkg::AGE_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttsmt_pkg::CFG_ENABLE:    enable    <= cfg_data[0];
        ttsmt_pkg::CFG_AGE_LIMIT: age_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks <= '0;
      next_ref  <= '0;
      valid     <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid <= valid_next;
      rd_v  <= cmd.scan_issue;
      if (cmd.accept && (mode == ttsmt_pkg::MODE_STORE)) begin
        next_ref <= next_ref + 1'b1;
      end
      if (cmd.accept && (mode == ttsmt_pkg::MODE_TICK)) begin
        now_ticks <= now_ticks + 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod  <= {{(ttsmt_pkg::TS_W-ttsmt_pkg::SEC_W){1'b0}}, sec_cap} *
             {{(ttsmt_pkg::TS_W-ttsmt_pkg::NSEC_W){1'b0}}, ttsmt_pkg::NS_PER_SEC};
    ts    <= prod + {{(ttsmt_pkg::TS_W-ttsmt_pkg::NSEC_W){1'b0}}, nsec_cap};
    idx_d <= idx;

    if (cmd.accept) begin
      op         <= ttsmt_pkg::mode_t'(mode);
      key        <= (mode == ttsmt_pkg::MODE_STORE) ? next_ref
                                                    : report_ref[ttsmt_pkg::REF_W-1:0];
      tag_cap    <= packet_tag;
      sec_cap    <= report_sec;
      nsec_cap   <= report_nsec;
      idx        <= '0;
      dup        <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      aged_mask  <= '0;
    end else if (cmd.emit) begin
      aged_mask <= aged_mask & ~(ONE << idx);
    end else begin
      aged_mask <= aged_mask_next;
    end

    if (cmd.scan_issue || cmd.seek_step) begin
      idx <= idx + 1'b1;
    end
    if (cmd.idx_clear) begin
      idx <= '0;
    end
    if (cmd.emit) begin
      idx <= idx + 1'b1;
    end

    if (rd_v) begin
      if (ref_eq && (op == ttsmt_pkg::MODE_STORE)) begin
        dup <= 1'b1;
      end
      if (ref_eq && (op == ttsmt_pkg::MODE_REPORT) && !hit_found) begin
        hit_found <= 1'b1;
        hit_slot  <= idx_d;
        hit_tag   <= rd_tag;
      end
      if (!slot_valid && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx_d;
      end
    end

    if (load) begin
      status       <= status_next;
      ref_number   <= ref_next;
      tag_out      <= tag_ext[ttsmt_pkg::TAG_OUT_W-1:0];
      timestamp_ns <= ts_next;
      last         <= last_next;
    end
  end

endmodule

// ===== hdl/tx_timestamp_match_table_top.sv =====
// Top level of the transmit timestamp match table.
// One item is handled at a time. A store or report with matching enabled walks all
// TABLE_DEPTH entries through the single read port of the entry RAM, one entry per
// cycle, before its result is loaded; a store or report with matching disabled
// skips the walk and goes straight to its result. A tick walks all entries the same
// way, then steps through the slots and emits each aged entry as its own result.
// The result register lets the next item transfer in while a result still waits on
// out_stall. Reset clears the valid bits of all entries at once; no clearing pass is
// needed.
module tx_timestamp_match_table_top #(
  parameter int TABLE_DEPTH = ttsmt_pkg::TABLE_DEPTH_DEF,
  parameter int TAG_BITS    = ttsmt_pkg::TAG_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [TAG_BITS-1:0]               packet_tag,
  input  logic [ttsmt_pkg::REF_IN_W-1:0]    report_ref,
  input  logic [ttsmt_pkg::SEC_W-1:0]       report_sec,
  input  logic [ttsmt_pkg::NSEC_W-1:0]      report_nsec,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ttsmt_pkg::STATUS_W-1:0]    status,
  output logic [ttsmt_pkg::REF_W-1:0]       ref_number,
  output logic [ttsmt_pkg::TAG_OUT_W-1:0]   tag_out,
  output logic [ttsmt_pkg::TS_W-1:0]        timestamp_ns,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttsmt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ttsmt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ttsmt_pkg::ctrl_cmd_t  cmd;
  ttsmt_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  ttsmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  ttsmt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .packet_tag   (packet_tag),
    .report_ref   (report_ref),
    .report_sec   (report_sec),
    .report_nsec  (report_nsec),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .ref_number   (ref_number),
    .tag_out      (tag_out),
    .timestamp_ns (timestamp_ns),
    .last         (last)
  );

endmodule

// ===== hdl/ttsmt_checker.sv =====
// Port-level checker for the transmit timestamp match table, with its bind.
module ttsmt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [1:0]                        mode,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ttsmt_pkg::STATUS_W-1:0]    status,
  input logic [ttsmt_pkg::REF_W-1:0]       ref_number,
  input logic [ttsmt_pkg::TAG_OUT_W-1:0]   tag_out,
  input logic [ttsmt_pkg::TS_W-1:0]        timestamp_ns,
  input logic                              last
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (mode == ttsmt_pkg::MODE_STORE ||
     mode == ttsmt_pkg::MODE_REPORT || mode == ttsmt_pkg::MODE_TICK)) |=> in_stall)
    else $error("block took another transfer before finishing an item");

  a_ts_only_on_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ttsmt_pkg::ST_MATCH) |-> (timestamp_ns == '0))
    else $error("timestamp set on a result that is not a match");

  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ttsmt_pkg::ST_AGED) |-> last)
    else $error("non-aging result without last");

  a_unknown_no_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ttsmt_pkg::ST_UNKNOWN) |-> (tag_out == '0))
    else $error("unknown report carries a tag");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(ref_number) && $stable(status)))
    else $error("stalled result changed");

endmodule

bind tx_timestamp_match_table_top ttsmt_checker u_ttsmt_checker (.*);

// ===== dv/tx_timestamp_match_table_top_test.sv =====
// Self-checking testbench for the transmit timestamp match table.
typedef struct packed {
  ttsmt_pkg::status_t                st;
  logic [ttsmt_pkg::REF_W-1:0]       refn;
  logic [ttsmt_pkg::TAG_OUT_W-1:0]   tag;
  logic [ttsmt_pkg::TS_W-1:0]        ts;
  logic                              last;
} tstamp_result_t;

class tstamp_table_predictor;
  bit                              slot_busy [ttsmt_pkg::TABLE_DEPTH_DEF];
  logic [ttsmt_pkg::REF_W-1:0]     slot_ref  [ttsmt_pkg::TABLE_DEPTH_DEF];
  logic [ttsmt_pkg::TAG_OUT_W-1:0] slot_tag  [ttsmt_pkg::TABLE_DEPTH_DEF];
  logic [ttsmt_pkg::TIME_W-1:0]    slot_time [ttsmt_pkg::TABLE_DEPTH_DEF];
  logic [ttsmt_pkg::TIME_W-1:0]    tick_count;
  logic [ttsmt_pkg::REF_W-1:0]     ref_counter;
  bit                              matching_on;
  logic [ttsmt_pkg::AGE_W-1:0]     age_limit;
  tstamp_result_t                  pending_results[$];
  int                              mismatch_count;

  function new();
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    tick_count     = '0;
    ref_counter    = '0;
    matching_on    = 1'b1;
    age_limit      = ttsmt_pkg::AGE_LIMIT_RST;
    mismatch_count = 0;
  endfunction

  function void apply_reg(logic [ttsmt_pkg::CFG_INDEX_W-1:0] idx,
                          logic [ttsmt_pkg::CFG_DATA_W-1:0] data);
    if (idx == ttsmt_pkg::CFG_ENABLE) matching_on = data[0];
    else if (idx == ttsmt_pkg::CFG_AGE_LIMIT) age_limit = data[ttsmt_pkg::AGE_W-1:0];
  endfunction

  function void push_result(ttsmt_pkg::status_t st, logic [ttsmt_pkg::REF_W-1:0] refn,
                            logic [ttsmt_pkg::TAG_OUT_W-1:0] tag,
                            logic [ttsmt_pkg::TS_W-1:0] ts, logic last);
    tstamp_result_t r;
    r.st = st; r.refn = refn; r.tag = tag; r.ts = ts; r.last = last;
    pending_results.push_back(r);
  endfunction

  function void note_transfer(logic [1:0] mode, logic [7:0] tag, logic [15:0] rref,
                              logic [ttsmt_pkg::SEC_W-1:0] sec,
                              logic [ttsmt_pkg::NSEC_W-1:0] nsec);
    logic [ttsmt_pkg::REF_W-1:0] key;
    logic [63:0]                 ns_total;
    int                          free_slot;
    int                          aged;
    bit                          done;
    key = rref[ttsmt_pkg::REF_W-1:0];
    free_slot = -1;
    aged = 0;
    done = 1'b0;
    case (mode)
      ttsmt_pkg::MODE_STORE: begin
        key = ref_counter;
        ref_counter = ref_counter + 1'b1;
        if (!matching_on) begin
          push_result(ttsmt_pkg::ST_DISABLED, key, tag, '0, 1'b1);
          return;
        end
        for (int i = 0; i < ttsmt_pkg::TABLE_DEPTH_DEF; i++) begin
          if (!done && slot_busy[i] && slot_ref[i] == key) begin
            push_result(ttsmt_pkg::ST_DUP, key, tag, '0, 1'b1);
            done = 1'b1;
          end
          if (!slot_busy[i] && free_slot < 0) free_slot = i;
        end
        if (done) return;
        if (free_slot < 0) begin
          push_result(ttsmt_pkg::ST_FULL, key, tag, '0, 1'b1);
          return;
        end
        slot_busy[free_slot] = 1'b1;
        slot_ref[free_slot]  = key;
        slot_tag[free_slot]  = tag;
        slot_time[free_slot] = tick_count;
        push_result(ttsmt_pkg::ST_STORED, key, tag, '0, 1'b1);
      end
      ttsmt_pkg::MODE_REPORT: begin
        if (!matching_on) begin
          push_result(ttsmt_pkg::ST_DISABLED, key, '0, '0, 1'b1);
          return;
        end
        for (int i = 0; i < ttsmt_pkg::TABLE_DEPTH_DEF; i++) begin
          if (!done && slot_busy[i] && slot_ref[i] == key) begin
            ns_total = {32'd0, sec} * 64'd1000000000 + {34'd0, nsec};
            slot_busy[i] = 1'b0;
            push_result(ttsmt_pkg::ST_MATCH, key, slot_tag[i],
                        ns_total[ttsmt_pkg::TS_W-1:0], 1'b1);
            done = 1'b1;
          end
        end
        if (!done) push_result(ttsmt_pkg::ST_UNKNOWN, key, '0, '0, 1'b1);
      end
      ttsmt_pkg::MODE_TICK: begin
        tick_count = tick_count + 1'b1;
        for (int i = 0; i < ttsmt_pkg::TABLE_DEPTH_DEF; i++) begin
          if (slot_busy[i] && (tick_count - slot_time[i]) > {16'd0, age_limit}) begin
            slot_busy[i] = 1'b0;
            push_result(ttsmt_pkg::ST_AGED, slot_ref[i], slot_tag[i], '0, 1'b0);
            aged++;
          end
        end
        if (aged > 0) pending_results[pending_results.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic [ttsmt_pkg::STATUS_W-1:0] st,
                             logic [ttsmt_pkg::REF_W-1:0] refn,
                             logic [ttsmt_pkg::TAG_OUT_W-1:0] tag,
                             logic [ttsmt_pkg::TS_W-1:0] ts, logic last);
    tstamp_result_t e;
    if (pending_results.size() == 0) begin
      $error("result with nothing awaited: status %0d ref %0d", st, refn);
      mismatch_count++;
      return;
    end
    e = pending_results.pop_front();
    if (st !== e.st) begin
      $error("status expected %0d actual %0d", e.st, st);
      mismatch_count++;
    end
    if (refn !== e.refn) begin
      $error("ref_number expected %0d actual %0d", e.refn, refn);
      mismatch_count++;
    end
    if (tag !== e.tag) begin
      $error("tag_out expected %0d actual %0d", e.tag, tag);
      mismatch_count++;
    end
    if (ts !== e.ts) begin
      $error("timestamp_ns expected %0d actual %0d", e.ts, ts);
      mismatch_count++;
    end
    if (last !== e.last) begin
      $error("last expected %0d actual %0d", e.last, last);
      mismatch_count++;
    end
  endfunction

  function int busy_count();
    int n;
    n = 0;
    foreach (slot_busy[i]) if (slot_busy[i]) n++;
    return n;
  endfunction

  function logic [ttsmt_pkg::REF_W-1:0] pick_pending_ref();
    int busy_idx[$];
    foreach (slot_busy[i]) if (slot_busy[i]) busy_idx.push_back(i);
    if (busy_idx.size() == 0) return ttsmt_pkg::REF_W'($urandom);
    return slot_ref[busy_idx[$urandom_range(0, busy_idx.size()-1)]];
  endfunction
endclass

module tx_timestamp_match_table_top_test;
  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int         SETTLE_CYCLES = 200;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              in_valid;
  logic                              in_stall;
  logic [1:0]                        mode;
  logic [ttsmt_pkg::TAG_BITS_DEF-1:0] packet_tag;
  logic [ttsmt_pkg::REF_IN_W-1:0]    report_ref;
  logic [ttsmt_pkg::SEC_W-1:0]       report_sec;
  logic [ttsmt_pkg::NSEC_W-1:0]      report_nsec;
  logic                              out_valid;
  logic                              out_stall;
  logic [ttsmt_pkg::STATUS_W-1:0]    status;
  logic [ttsmt_pkg::REF_W-1:0]       ref_number;
  logic [ttsmt_pkg::TAG_OUT_W-1:0]   tag_out;
  logic [ttsmt_pkg::TS_W-1:0]        timestamp_ns;
  logic                              last;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [ttsmt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ttsmt_pkg::CFG_DATA_W-1:0]  cfg_data;

  bit                                idle_on;
  tstamp_table_predictor             table_pred;

  tx_timestamp_match_table_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      table_pred.check_result(status, ref_number, tag_out, timestamp_ns, last);

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [ttsmt_pkg::NSEC_W-1:0] rand_nsec();
    return ttsmt_pkg::NSEC_W'($urandom_range(0, 999999999));
  endfunction

  task automatic write_reg(input logic [ttsmt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ttsmt_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    table_pred.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [1:0] m, input logic [7:0] tg, input logic [15:0] rr,
                           input logic [ttsmt_pkg::SEC_W-1:0] sec,
                           input logic [ttsmt_pkg::NSEC_W-1:0] ns);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    packet_tag  <= tg;
    report_ref  <= rr;
    report_sec  <= sec;
    report_nsec <= ns;
    do @(posedge clk); while (in_stall);
    table_pred.note_transfer(m, tg, rr, sec, ns);
    @(negedge clk);
  endtask

  task automatic send_mode(input logic [1:0] m);
    send_item(m, 8'($urandom), 16'($urandom), $urandom, rand_nsec());
  endtask

  task automatic hold_until_empty();
    in_valid <= 1'b0;
    while (table_pred.pending_results.size() > 0) @(negedge clk);
  endtask

  task automatic drain();
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic random_item();
    int          r;
    logic [15:0] rr;
    r  = $urandom_range(0, 99);
    rr = 16'($urandom);
    if (r < 40) send_mode(ttsmt_pkg::MODE_STORE);
    else if (r < 75) begin
      if (r < 68 && table_pred.busy_count() > 0)
        rr[ttsmt_pkg::REF_W-1:0] = table_pred.pick_pending_ref();
      send_item(ttsmt_pkg::MODE_REPORT, 8'($urandom), rr, $urandom, rand_nsec());
    end
    else if (r < 95) send_mode(ttsmt_pkg::MODE_TICK);
    else send_mode(MODE_IGNORED);
  endtask

  task automatic run_phase(input bit en, input logic [ttsmt_pkg::AGE_W-1:0] age,
                           input int n);
    drain();
    write_reg(ttsmt_pkg::CFG_ENABLE, {15'd0, en});
    write_reg(ttsmt_pkg::CFG_AGE_LIMIT, age);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) hold_until_empty();
      random_item();
    end
  endtask

  initial begin
    table_pred  = new();
    idle_on     = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = ttsmt_pkg::MODE_STORE;
    packet_tag  = '0;
    report_ref  = '0;
    report_sec  = '0;
    report_nsec = '0;
    cfg_valid   = 1'b0;
    cfg_index   = ttsmt_pkg::CFG_ENABLE;
    cfg_data    = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_reg(ttsmt_pkg::CFG_ENABLE, 16'd1);
    write_reg(ttsmt_pkg::CFG_AGE_LIMIT, ttsmt_pkg::AGE_LIMIT_RST);
    idle_on = 1'b1;

    send_item(ttsmt_pkg::MODE_STORE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 30'd999999999);
    send_item(ttsmt_pkg::MODE_STORE, 8'h00, 16'h0000, 32'h0, 30'd0);
    send_mode(ttsmt_pkg::MODE_STORE);
    send_item(ttsmt_pkg::MODE_REPORT, 8'($urandom), 16'hF001, 32'hFFFF_FFFF,
              30'd999999999);
    send_item(ttsmt_pkg::MODE_REPORT, 8'($urandom), 16'h0000, 32'h0, 30'd0);
    send_item(ttsmt_pkg::MODE_REPORT, 8'hFF, 16'hFFFF, $urandom, rand_nsec());
    send_mode(MODE_IGNORED);
    send_mode(ttsmt_pkg::MODE_TICK);
    while (table_pred.busy_count() < ttsmt_pkg::TABLE_DEPTH_DEF)
      send_mode(ttsmt_pkg::MODE_STORE);
    send_mode(ttsmt_pkg::MODE_STORE);

    drain();
    write_reg(ttsmt_pkg::CFG_AGE_LIMIT, 16'd1);
    send_mode(ttsmt_pkg::MODE_TICK);
    send_mode(ttsmt_pkg::MODE_TICK);
    send_mode(ttsmt_pkg::MODE_TICK);

    drain();
    write_reg(ttsmt_pkg::CFG_ENABLE, 16'd0);
    send_mode(ttsmt_pkg::MODE_STORE);
    send_mode(ttsmt_pkg::MODE_REPORT);
    send_mode(ttsmt_pkg::MODE_TICK);

    drain();
    write_reg(ttsmt_pkg::CFG_ENABLE, 16'd1);
    write_reg(ttsmt_pkg::CFG_AGE_LIMIT, 16'hFFFF);
    send_mode(ttsmt_pkg::MODE_STORE);

    run_phase(1'b1, 16'd3, 24);
    run_phase(1'b1, ttsmt_pkg::AGE_W'($urandom_range(2, 40)), 24);
    run_phase(1'b0, 16'd2, 12);
    idle_on = 1'b0;
    run_phase(1'b1, 16'hFFFF, 24);

    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (table_pred.mismatch_count == 0 && table_pred.pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== tx_timestamp_match_table_top.f =====
hdl/ttsmt_pkg.sv
hdl/ttsmt_ram.sv
hdl/ttsmt_ctrl.sv
hdl/ttsmt_dpath.sv
hdl/tx_timestamp_match_table_top.sv
hdl/ttsmt_checker.sv
dv/tx_timestamp_match_table_top_test.sv
